@@ sv/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared codes and types for the MOESI directory controller.
// ----------------------------------------------------------------------------
package mdc_pkg;

   // request kinds
   localparam logic [2:0] KIND_READ      = 3'd0;
   localparam logic [2:0] KIND_WRITE     = 3'd1;
   localparam logic [2:0] KIND_WRITEBACK = 3'd2;
   localparam logic [2:0] KIND_EVICT     = 3'd3;
   localparam logic [2:0] KIND_INSTALL   = 3'd4;

   // result kinds
   localparam logic [1:0] OUT_NONE       = 2'd0;
   localparam logic [1:0] OUT_DATA       = 2'd1;
   localparam logic [1:0] OUT_TRANSFER   = 2'd2;
   localparam logic [1:0] OUT_INVALIDATE = 2'd3;

   // per-node line states
   localparam logic [2:0] ST_INVALID   = 3'd0;
   localparam logic [2:0] ST_SHARED    = 3'd1;
   localparam logic [2:0] ST_EXCLUSIVE = 3'd2;
   localparam logic [2:0] ST_OWNED     = 3'd3;
   localparam logic [2:0] ST_MODIFIED  = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_HOME_NODE = 2'd0;
   localparam logic [1:0] CSR_MULTICAST = 2'd1;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // decision of the directory update for one request
   typedef struct packed {
      logic        found;
      logic [5:0]  holder;
      logic        hint;
      logic [63:0] mask;
   } dir_action_type;

endpackage

@@ sv/mdc_tag_cam.sv @@
// ----------------------------------------------------------------------------
// mdc_tag_cam
// Line tag registers with a parallel compare; reports the highest matching line.
// ----------------------------------------------------------------------------
module mdc_tag_cam #(
   parameter int LINES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       write_en,
   input  logic [$clog2(LINES)-1:0]   write_index,
   input  logic [31:0]                write_tag,
   input  logic [31:0]                lookup_tag,
   output logic                       hit,
   output logic [$clog2(LINES)-1:0]   hit_index
);
   localparam int LW = $clog2(LINES);

   logic [31:0] tags_ff [LINES];

   // load a tag on install, clear all on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            tags_ff[i] <= '0;
         end
      end else if (write_en) begin
         tags_ff[write_index] <= write_tag;
      end
   end

   // compare all lines, the highest index wins
   always_comb begin
      hit       = 1'b0;
      hit_index = '0;
      for (int i = 0; i < LINES; i++) begin
         if (tags_ff[i] == lookup_tag) begin
            hit       = 1'b1;
            hit_index = LW'(i);
         end
      end
   end

endmodule

@@ sv/mdc_mod_unit.sv @@
// ----------------------------------------------------------------------------
// mdc_mod_unit
// Home line of a missing address: (address / 4) mod LINES by reciprocal
// multiply, quotient back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module mdc_mod_unit #(
   parameter int LINES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                address,
   output logic                       done,
   output logic [$clog2(LINES)-1:0]   remainder
);
   localparam int LW = $clog2(LINES);
   localparam logic [29:0] DIVISOR = 30'(LINES);
   localparam logic [29:0] RECIP   = 30'((64'd1 << 30) / LINES);

   logic [29:0]   x_ff, x_in;
   logic [29:0]   q_ff, q_in;
   logic [29:0]   qd_ff, qd_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [59:0]   prod;
   logic [29:0]   diff;
   logic [29:0]   fix;

   // estimated quotient is exact or one short; one subtract corrects it
   always_comb begin
      prod = 60'(x_ff) * 60'(RECIP);
      diff = x_ff - qd_ff;
      fix  = (diff >= DIVISOR) ? (diff - DIVISOR) : diff;
   end

   // advance multiply, back-multiply and correct, in that order
   always_comb begin
      x_in    = x_ff;
      q_in    = q_ff;
      qd_in   = qd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         x_in    = address[31:2];
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            q_in = prod[59:30];
         end else if (cnt_ff == 2'd1) begin
            qd_in = q_ff * DIVISOR;
         end else begin
            rem_in  = fix[LW-1:0];
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      q_ff   <= q_in;
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ sv/mdc_dir_store.sv @@
// ----------------------------------------------------------------------------
// mdc_dir_store
// Line value memory and directory row memory, one read and one write port each.
// ----------------------------------------------------------------------------
module mdc_dir_store #(
   parameter int LINES = 64,
   parameter int NODES = 64
) (
   input  logic                       clock,
   input  logic [$clog2(LINES)-1:0]   read_index,
   input  logic                       value_we,
   input  logic [$clog2(LINES)-1:0]   value_index,
   input  logic [31:0]                value_wdata,
   input  logic                       row_we,
   input  logic [$clog2(LINES)-1:0]   row_index,
   input  logic [NODES*3-1:0]         row_wdata,
   output logic [31:0]                value_rdata,
   output logic [NODES*3-1:0]         row_rdata
);
   logic [31:0]        value_mem [LINES];
   logic [NODES*3-1:0] row_mem   [LINES];
   logic [31:0]        value_rd_ff;
   logic [NODES*3-1:0] row_rd_ff;

   // write ports
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_index] <= value_wdata;
      end
      if (row_we) begin
         row_mem[row_index] <= row_wdata;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      value_rd_ff <= value_mem[read_index];
      row_rd_ff   <= row_mem[read_index];
   end

   assign value_rdata = value_rd_ff;
   assign row_rdata   = row_rd_ff;

endmodule

@@ sv/mdc_dir_logic.sv @@
// ----------------------------------------------------------------------------
// mdc_dir_logic
// Directory row update: holder choice for reads, invalidation for writes,
// source line cleared for writebacks and evicts.
module mdc_dir_logic #(
   parameter int NODES = 64
) (
   input  logic [2:0]                 kind,
   input  logic [$clog2(NODES)-1:0]   source,
   input  logic [NODES*3-1:0]         row,
   output logic [NODES*3-1:0]         new_row,
   output mdc_pkg::dir_action_type    action
);
   import mdc_pkg::*;

   localparam int NW = $clog2(NODES);

   logic [3:0]          pf;
   logic [NW-1:0]       ph [4];
   logic [2:0]          prio [4];
   logic [2:0]          st;
   logic [NODES-1:0]    mask;

   // highest node in each state, searched independently
   always_comb begin
      prio[0] = ST_MODIFIED;
      prio[1] = ST_EXCLUSIVE;
      prio[2] = ST_OWNED;
      prio[3] = ST_SHARED;
      for (int p = 0; p < 4; p++) begin
         pf[p] = 1'b0;
         ph[p] = '0;
         for (int i = 0; i < NODES; i++) begin
            if (row[i*3 +: 3] == prio[p]) begin
               pf[p] = 1'b1;
               ph[p] = NW'(i);
            end
         end
      end
   end

   // invalidation mask of a write
   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         st      = row[i*3 +: 3];
         mask[i] = (NW'(i) != source) && (st != ST_INVALID);
      end
   end

   always_comb begin
      new_row       = row;
      action        = '0;
      case (kind)
         KIND_READ: begin
            if (pf[0]) begin
               action.found  = 1'b1;
               action.holder = 6'(ph[0]);
               new_row[ph[0]*3 +: 3] = ST_OWNED;
            end else if (pf[1]) begin
               action.found  = 1'b1;
               action.holder = 6'(ph[1]);
               action.hint   = 1'b1;
               new_row[ph[1]*3 +: 3] = ST_SHARED;
            end else if (pf[2]) begin
               action.found  = 1'b1;
               action.holder = 6'(ph[2]);
            end else if (pf[3]) begin
               action.found  = 1'b1;
               action.holder = 6'(ph[3]);
               action.hint   = 1'b1;
            end
            new_row[source*3 +: 3] = action.found ? ST_SHARED : ST_EXCLUSIVE;
         end
         KIND_WRITE: begin
            for (int i = 0; i < NODES; i++) begin
               if (mask[i]) begin
                  new_row[i*3 +: 3] = ST_INVALID;
               end
            end
            new_row[source*3 +: 3] = ST_MODIFIED;
            action.mask = 64'(mask);
         end
         default: begin
            new_row[source*3 +: 3] = ST_INVALID;
         end
      endcase
   end

endmodule

@@ sv/moesi_directory_controller_unit.sv @@
// Result path: home-line remainder, memory read, row update into the result
//   register, transfer; a write with multicast off then sends its unicast
//   invalidates one by one. Install and ignored requests answer from lookup.
// Requests: one at a time, taken only while idle; the directory row
//   read-modify-write and the remainder unit set the pace.
// Reset: tags clear at once, then a pass over all LINES lines zeros line
//   values and directory rows; requests wait during that pass.
// ----------------------------------------------------------------------------
// moesi_directory_controller_unit
// Directory home node for MOESI coherence with tag lookup and row memory.
// ----------------------------------------------------------------------------
module moesi_directory_controller_unit #(
   parameter int LINES = 64,
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_source_node,
   input  logic [31:0] req_line_address,
   input  logic [31:0] req_write_value,
   input  logic [5:0]  req_install_slot,
   input  logic [31:0] req_packet_number,
   input  logic [31:0] req_arrival_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_origin_node,
   output logic [5:0]  rsp_dest_node,
   output logic [31:0] rsp_out_address,
   output logic [31:0] rsp_out_value,
   output logic        rsp_transfer_hint,
   output logic [63:0] rsp_invalidate_mask,
   output logic [31:0] rsp_out_packet_number,
   output logic [31:0] rsp_out_time,
   output logic        rsp_last_of_run
);
   import mdc_pkg::*;

   localparam int LW = $clog2(LINES);
   localparam int NW = $clog2(NODES);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOOKUP, S_UPDATE, S_UNICAST, S_RESP
   } state_type;

   state_type      state_ff;
   logic [LW-1:0]  clr_ff;
   logic [7:0]     home_ff;
   logic           mcast_ff;

   logic [2:0]     kind_ff;
   logic [5:0]     src_ff;
   logic [31:0]    addr_ff;
   logic [31:0]    wval_ff;
   logic [5:0]     slot_ff;
   logic [31:0]    pn_ff;
   logic [31:0]    time_ff;
   logic [LW-1:0]  idx_ff;
   logic [63:0]    uni_ff;

   logic           rsp_valid_ff;
   logic [1:0]     o_kind_ff;
   logic [7:0]     o_origin_ff;
   logic [5:0]     o_dest_ff;
   logic [31:0]    o_addr_ff;
   logic [31:0]    o_value_ff;
   logic           o_hint_ff;
   logic [63:0]    o_mask_ff;
   logic           o_last_ff;

   logic           req_xfer, rsp_xfer;
   logic           cam_hit;
   logic [LW-1:0]  cam_idx;
   logic           mod_done;
   logic [LW-1:0]  mod_rem;
   logic [LW-1:0]  line_idx;
   logic [10:0]    slot_ext;
   logic           slot_ok, src_ok, is_install, is_request;
   logic           install_we;
   logic           value_we, row_we;
   logic [LW-1:0]  value_index, row_index;
   logic [31:0]    value_wdata, value_rdata;
   logic [NODES*3-1:0] row_wdata, row_rdata, new_row;
   dir_action_type action;
   logic [5:0]     low_bit;
   logic [63:0]    uni_next;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign slot_ext   = {5'd0, slot_ff};
   assign slot_ok    = slot_ext < 11'(LINES);
   assign src_ok     = {1'b0, src_ff} < 7'(NODES);
   assign is_install = (kind_ff == KIND_INSTALL);
   assign is_request = (kind_ff < KIND_INSTALL) && src_ok;
   assign install_we = (state_ff == S_LOOKUP) && is_install && slot_ok;
   assign line_idx   = cam_hit ? cam_idx : mod_rem;

   // tag lookup
   mdc_tag_cam #(.LINES(LINES)) u_cam (
      .clock       (clock),
      .reset       (reset),
      .write_en    (install_we),
      .write_index (slot_ext[LW-1:0]),
      .write_tag   (addr_ff),
      .lookup_tag  (addr_ff),
      .hit         (cam_hit),
      .hit_index   (cam_idx)
   );

   // home line of a missing address
   mdc_mod_unit #(.LINES(LINES)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer),
      .address   (req_line_address),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // memory write port selection
   always_comb begin
      value_we    = 1'b0;
      value_index = idx_ff;
      value_wdata = wval_ff;
      row_we      = 1'b0;
      row_index   = idx_ff;
      row_wdata   = new_row;
      case (state_ff)
         S_CLEAR: begin
            value_we    = 1'b1;
            value_index = clr_ff;
            value_wdata = '0;
            row_we      = 1'b1;
            row_index   = clr_ff;
            row_wdata   = '0;
         end
         S_LOOKUP: begin
            value_we    = install_we;
            value_index = slot_ext[LW-1:0];
         end
         S_UPDATE: begin
            row_we   = 1'b1;
            value_we = (kind_ff == KIND_WRITEBACK) || (kind_ff == KIND_EVICT);
         end
         default: begin
         end
      endcase
   end

   mdc_dir_store #(.LINES(LINES), .NODES(NODES)) u_store (
      .clock       (clock),
      .read_index  (line_idx),
      .value_we    (value_we),
      .value_index (value_index),
      .value_wdata (value_wdata),
      .row_we      (row_we),
      .row_index   (row_index),
      .row_wdata   (row_wdata),
      .value_rdata (value_rdata),
      .row_rdata   (row_rdata)
   );

   mdc_dir_logic #(.NODES(NODES)) u_logic (
      .kind    (kind_ff),
      .source  (src_ff[NW-1:0]),
      .row     (row_rdata),
      .new_row (new_row),
      .action  (action)
   );

   // lowest pending unicast target
   always_comb begin
      low_bit = '0;
      for (int i = 63; i >= 0; i--) begin
         if (uni_ff[i]) begin
            low_bit = 6'(i);
         end
      end
      uni_next = uni_ff & ~(64'd1 << low_bit);
   end

   // control, request capture and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         home_ff      <= '0;
         mcast_ff     <= 1'b1;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_HOME_NODE) begin
               home_ff <= csr_write_data;
            end else if (csr_index == CSR_MULTICAST) begin
               mcast_ff <= csr_write_data[0];
            end
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + LW'(1);
               if (clr_ff == LW'(LINES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_xfer) begin
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               if (!is_request) begin
                  rsp_valid_ff <= 1'b1;
                  uni_ff       <= '0;
                  state_ff     <= S_RESP;
               end else if (mod_done) begin
                  idx_ff   <= line_idx;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (kind_ff == KIND_WRITE && !mcast_ff && action.mask != '0) begin
                  uni_ff   <= action.mask;
                  state_ff <= S_UNICAST;
               end else begin
                  uni_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RESP;
               end
            end
            S_UNICAST: begin
               uni_ff       <= uni_next;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp_xfer) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= (uni_ff != '0) ? S_UNICAST : S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end

      // hold the request fields
      if (req_xfer) begin
         kind_ff <= req_kind;
         src_ff  <= req_source_node;
         addr_ff <= req_line_address;
         wval_ff <= req_write_value;
         slot_ff <= req_install_slot;
         pn_ff   <= req_packet_number;
         time_ff <= req_arrival_time + 32'd1;
      end

      // build result payload
      if (state_ff == S_LOOKUP || state_ff == S_UPDATE) begin
         o_kind_ff   <= OUT_NONE;
         o_origin_ff <= '0;
         o_dest_ff   <= '0;
         o_addr_ff   <= '0;
         o_value_ff  <= '0;
         o_hint_ff   <= 1'b0;
         o_mask_ff   <= '0;
         o_last_ff   <= 1'b1;
         if (state_ff == S_UPDATE) begin
            if (kind_ff == KIND_READ && action.found) begin
               o_kind_ff   <= OUT_TRANSFER;
               o_origin_ff <= {2'b00, src_ff};
               o_dest_ff   <= action.holder;
               o_addr_ff   <= addr_ff;
               o_hint_ff   <= action.hint;
            end else if (kind_ff == KIND_READ) begin
               o_kind_ff   <= OUT_DATA;
               o_origin_ff <= home_ff;
               o_dest_ff   <= src_ff;
               o_addr_ff   <= addr_ff;
               o_value_ff  <= value_rdata;
            end else if (kind_ff == KIND_WRITE && action.mask != '0) begin
               o_kind_ff   <= OUT_INVALIDATE;
               o_origin_ff <= home_ff;
               o_addr_ff   <= addr_ff;
               o_mask_ff   <= action.mask;
            end
         end
      end else if (state_ff == S_UNICAST) begin
         o_kind_ff   <= OUT_INVALIDATE;
         o_origin_ff <= home_ff;
         o_dest_ff   <= low_bit;
         o_addr_ff   <= addr_ff;
         o_value_ff  <= ALL_ONES;
         o_hint_ff   <= 1'b0;
         o_mask_ff   <= '0;
         o_last_ff   <= (uni_next == '0);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_out_kind          = o_kind_ff;
   assign rsp_origin_node       = o_origin_ff;
   assign rsp_dest_node         = o_dest_ff;
   assign rsp_out_address       = o_addr_ff;
   assign rsp_out_value         = o_value_ff;
   assign rsp_transfer_hint     = o_hint_ff;
   assign rsp_invalidate_mask   = o_mask_ff;
   assign rsp_out_packet_number = pn_ff;
   assign rsp_out_time          = time_ff;
   assign rsp_last_of_run       = o_last_ff;

endmodule
